>>> rtl/iisu_pkg.sv
// Package of shared types, constants and register codes for the integral image unit.
package iisu_pkg;

  // Default sizing of the line store and sum width.
  localparam int MAX_WIDTH_DEFAULT    = 4096;
  localparam int MAX_CHANNELS_DEFAULT = 4;
  localparam int SUM_BITS_DEFAULT     = 32;

  // Image height bound and the width of the row counter that follows from it.
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_BITS   = 12;

  // Register field widths.
  localparam int WIDTH_BITS   = 13;
  localparam int HEIGHT_BITS  = 13;
  localparam int CHAN_BITS    = 3;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  // Register values after reset.
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET    = 13'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET   = 13'd480;
  localparam logic [CHAN_BITS-1:0]   CHANNELS_RESET = 3'd3;
  localparam logic                   PLANAR_RESET   = 1'b0;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_PLANAR   = 2'd3
  } reg_index_t;

  // Raw configuration as held by the register block.
  typedef struct packed {
    logic [WIDTH_BITS-1:0]  image_width;
    logic [HEIGHT_BITS-1:0] image_height;
    logic [CHAN_BITS-1:0]   channel_count;
    logic                   planar_layout;
  } cfg_t;

endpackage

>>> rtl/iisu_cfg_regs.sv
// APB-style configuration registers of the integral image unit.
module iisu_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iisu_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [iisu_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [iisu_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output iisu_pkg::cfg_t                      cfg
);

  iisu_pkg::reg_index_t reg_index;
  logic                 write_strobe;

  assign reg_index    = iisu_pkg::reg_index_t'(paddr[3:2]);
  assign pready       = 1'b1;
  assign write_strobe = psel && penable && pwrite && pready;

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= iisu_pkg::WIDTH_RESET;
      cfg.image_height  <= iisu_pkg::HEIGHT_RESET;
      cfg.channel_count <= iisu_pkg::CHANNELS_RESET;
      cfg.planar_layout <= iisu_pkg::PLANAR_RESET;
    end else if (write_strobe) begin
      unique case (reg_index)
        iisu_pkg::REG_WIDTH:    cfg.image_width   <= pwdata[iisu_pkg::WIDTH_BITS-1:0];
        iisu_pkg::REG_HEIGHT:   cfg.image_height  <= pwdata[iisu_pkg::HEIGHT_BITS-1:0];
        iisu_pkg::REG_CHANNELS: cfg.channel_count <= pwdata[iisu_pkg::CHAN_BITS-1:0];
        iisu_pkg::REG_PLANAR:   cfg.planar_layout <= pwdata[0];
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    unique case (reg_index)
      iisu_pkg::REG_WIDTH:    prdata = iisu_pkg::APB_DATA_BITS'(cfg.image_width);
      iisu_pkg::REG_HEIGHT:   prdata = iisu_pkg::APB_DATA_BITS'(cfg.image_height);
      iisu_pkg::REG_CHANNELS: prdata = iisu_pkg::APB_DATA_BITS'(cfg.channel_count);
      iisu_pkg::REG_PLANAR:   prdata = iisu_pkg::APB_DATA_BITS'(cfg.planar_layout);
    endcase
  end

endmodule

>>> rtl/iisu_position.sv
// Raster position tracker and line-store address generator.
module iisu_position #(
  parameter int MAX_WIDTH    = iisu_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_CHANNELS = iisu_pkg::MAX_CHANNELS_DEFAULT,
  parameter int ADDR_BITS    = 12,
  parameter int COL_BITS     = 12,
  parameter int CH_BITS      = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 frame_start,
  input  iisu_pkg::cfg_t       cfg,
  output logic [ADDR_BITS-1:0] addr,
  output logic [CH_BITS-1:0]   ch_cur,
  output logic                 col_zero,
  output logic                 row_zero,
  output logic                 last
);

  localparam int WB = ((COL_BITS > iisu_pkg::WIDTH_BITS) ? COL_BITS : iisu_pkg::WIDTH_BITS) + 1;
  localparam int HB = iisu_pkg::ROW_BITS + 1;
  localparam int CB = ((CH_BITS > iisu_pkg::CHAN_BITS) ? CH_BITS : iisu_pkg::CHAN_BITS) + 1;
  localparam logic [WB-1:0] W_MAX = WB'(MAX_WIDTH);
  localparam logic [HB-1:0] H_MAX = HB'(iisu_pkg::MAX_HEIGHT);
  localparam logic [CB-1:0] C_MAX = CB'(MAX_CHANNELS);
  localparam logic [ADDR_BITS:0] PLANE_SIZE = (ADDR_BITS+1)'(MAX_WIDTH);

  logic [COL_BITS-1:0]           col, col_cur, col_next;
  logic [iisu_pkg::ROW_BITS-1:0] row, row_cur, row_next;
  logic [CH_BITS-1:0]            ch, ch_next;
  logic [WB-1:0] w_raw, w_eff, col_inc;
  logic [HB-1:0] h_raw, h_eff, row_inc;
  logic [CB-1:0] c_raw, c_eff, ch_inc;
  logic          col_end, row_end, ch_end;
  logic [ADDR_BITS:0] addr_full;

  // Clamp the registers to their legal ranges.
  always_comb begin
    w_raw = WB'(cfg.image_width);
    h_raw = HB'(cfg.image_height);
    c_raw = CB'(cfg.channel_count);
    w_eff = (w_raw == '0) ? WB'(1) : ((w_raw > W_MAX) ? W_MAX : w_raw);
    h_eff = (h_raw == '0) ? HB'(1) : ((h_raw > H_MAX) ? H_MAX : h_raw);
    c_eff = (c_raw == '0) ? CB'(1) : ((c_raw > C_MAX) ? C_MAX : c_raw);
  end

  // Current position: a frame start forces the origin.
  always_comb begin
    col_cur = frame_start ? '0 : col;
    row_cur = frame_start ? '0 : row;
    ch_cur  = frame_start ? '0 : ch;
    col_inc = WB'(col_cur) + WB'(1);
    row_inc = HB'(row_cur) + HB'(1);
    ch_inc  = CB'(ch_cur) + CB'(1);
    col_end = (col_inc >= w_eff);
    row_end = (row_inc >= h_eff);
    ch_end  = (ch_inc >= c_eff);
    col_zero = (col_cur == '0);
    row_zero = (row_cur == '0);
    last     = col_end && row_end && ch_end;
    addr_full = (ADDR_BITS+1)'(ch_cur) * PLANE_SIZE + (ADDR_BITS+1)'(col_cur);
    addr      = addr_full[ADDR_BITS-1:0];
  end

  // Next position in layout order.
  always_comb begin
    col_next = col_cur;
    row_next = row_cur;
    ch_next  = ch_cur;
    if (cfg.planar_layout) begin
      col_next = col_end ? '0 : col_inc[COL_BITS-1:0];
      if (col_end) begin
        row_next = row_end ? '0 : row_inc[iisu_pkg::ROW_BITS-1:0];
        if (row_end) begin
          ch_next = ch_end ? '0 : ch_inc[CH_BITS-1:0];
        end
      end
    end else begin
      ch_next = ch_end ? '0 : ch_inc[CH_BITS-1:0];
      if (ch_end) begin
        col_next = col_end ? '0 : col_inc[COL_BITS-1:0];
        if (col_end) begin
          row_next = row_end ? '0 : row_inc[iisu_pkg::ROW_BITS-1:0];
        end
      end
    end
  end

  // Position registers move on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ch  <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
      ch  <= ch_next;
    end
  end

endmodule

>>> rtl/iisu_line_store.sv
// Single-port-write, single-port-read line store with registered read data.
module iisu_line_store #(
  parameter int DEPTH     = 16384,
  parameter int ADDR_BITS = 14,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/integral_image_streaming_unit.sv
// Top level of the streaming integral image (summed-area table) unit.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------
//   input    | in        | in_valid/in_stall  | sample[7:0], frame_start
//   output   | out       | out_valid/out_stall| area_sum[31:0], frame_last
//   config   | in/out    | APB psel/penable   | paddr[3:0], pwdata/prdata[31:0]
//
// One word is accepted every cycle while in_stall is low. The line-store read is registered
// together with the word in the sum stage, and the sum feeds the output register, which
// presents the result until it is taken.
// Reset is synchronous and clears position, pipeline valids and row sums; the line
// store needs no clearing pass. A stalled output holds the sum stage, which in turn
// stalls the input in the same cycle; no word is lost or repeated.
module integral_image_streaming_unit #(
  parameter int MAX_WIDTH    = iisu_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_CHANNELS = iisu_pkg::MAX_CHANNELS_DEFAULT,
  parameter int SUM_BITS     = iisu_pkg::SUM_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iisu_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [iisu_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [iisu_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          sample,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [31:0]                         area_sum,
  output logic                                frame_last
);

  localparam int DEPTH     = MAX_CHANNELS * MAX_WIDTH;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int OUT_BITS  = (SUM_BITS < 32) ? SUM_BITS : 32;

  iisu_pkg::cfg_t cfg;

  logic                 accept;
  logic [ADDR_BITS-1:0] pos_addr;
  logic [CH_BITS-1:0]   pos_ch;
  logic                 pos_col_zero, pos_row_zero, pos_last;

  // Sum stage registers.
  logic                 s1_valid;
  logic [7:0]           s1_sample;
  logic [ADDR_BITS-1:0] s1_addr;
  logic [CH_BITS-1:0]   s1_ch;
  logic                 s1_col_zero, s1_row_zero, s1_last, s1_fwd;
  logic [SUM_BITS-1:0]  fwd_data;
  logic                 s1_fire;

  logic [SUM_BITS-1:0]  rd_data, above, running, area;
  logic [SUM_BITS-1:0]  row_sums [MAX_CHANNELS];
  logic [SUM_BITS-1:0]  area_q;

  iisu_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iisu_position #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ADDR_BITS    (ADDR_BITS),
    .COL_BITS     (COL_BITS),
    .CH_BITS      (CH_BITS)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .frame_start (frame_start),
    .cfg         (cfg),
    .addr        (pos_addr),
    .ch_cur      (pos_ch),
    .col_zero    (pos_col_zero),
    .row_zero    (pos_row_zero),
    .last        (pos_last)
  );

  iisu_line_store #(
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (SUM_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data (area),
    .rd_en   (accept),
    .rd_addr (pos_addr),
    .rd_data (rd_data)
  );

  // Handshake: the sum stage moves when the output register is free or being taken.
  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign accept   = in_valid && !in_stall;

  // Sum of the value above and the running row sum of this channel.
  always_comb begin
    above   = s1_row_zero ? '0 : (s1_fwd ? fwd_data : rd_data);
    running = s1_col_zero ? SUM_BITS'(s1_sample)
                          : row_sums[s1_ch] + SUM_BITS'(s1_sample);
    area    = above + running;
  end

  // Sum stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Sum stage payload; the word leaving this cycle forwards its sum to a follower
  // at the same line-store address, whose read saw the old contents.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= sample;
      s1_addr     <= pos_addr;
      s1_ch       <= pos_ch;
      s1_col_zero <= pos_col_zero;
      s1_row_zero <= pos_row_zero;
      s1_last     <= pos_last;
      s1_fwd      <= s1_fire && (s1_addr == pos_addr);
      fwd_data    <= area;
    end
  end

  // Running row sums per channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        row_sums[i] <= '0;
      end
    end else if (s1_fire) begin
      row_sums[s1_ch] <= running;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      area_q     <= area;
      frame_last <= s1_last;
    end
  end

  assign area_sum = 32'(area_q[OUT_BITS-1:0]);

`ifndef SYNTHESIS
  // An accepted word always lands in the sum stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word did not reach the sum stage");

  // A word leaving the sum stage always lands in the output register.
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("sum stage result did not reach the output register");

  // A held sum stage keeps its word and address.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_addr) && $stable(s1_sample)))
    else $error("sum stage changed while held");

  // With both stages full and the output stalled, the input must be stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while the pipeline is full");
`endif

endmodule
